### hw/rtl/itr_pkg.sv
package itr_pkg;

    // item geometry
    localparam int unsigned PAGE_BYTES   = 256;
    localparam int unsigned HEADER_BYTES = 256;
    localparam int unsigned SEQ_BYTES    = 4;
    localparam int unsigned MARKER_BYTES = 5;
    localparam logic [31:0] MAGIC_WOLF   = 32'h464C_4F57;

    // field widths
    localparam int unsigned OFFS_W = 25;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned LEN_W  = 9;

    // configuration register indexes
    localparam logic CFG_PARTITION_SIZE = 1'b0;
    localparam logic CFG_RESERVED_BYTES = 1'b1;

    // configuration reset values
    localparam logic [OFFS_W-1:0] PARTITION_SIZE_RST = 25'd262144;
    localparam logic [OFFS_W-1:0] RESERVED_BYTES_RST = 25'd8192;

    // input function codes
    localparam logic FUNC_DGRAM   = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    // result action codes
    typedef enum logic [1:0] {
        ACT_ACK    = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_MARKER = 2'd3
    } t_action;

    // job passed from the front to the back
    typedef enum logic [1:0] {
        JOB_START  = 2'd0,
        JOB_PAGE   = 2'd1,
        JOB_DONE   = 2'd2,
        JOB_REJECT = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [OFFS_W-1:0] woff;
        logic [CNT_W-1:0]  wcnt;
        logic [WORD_W-1:0] ack;
        logic [OFFS_W-1:0] moff;
    } t_job;

    typedef struct packed {
        t_action           action;
        logic [OFFS_W-1:0] flash_offset;
        logic [CNT_W-1:0]  byte_count;
        logic [WORD_W-1:0] ack_value;
        logic              last;
    } t_result;

    localparam int unsigned JOBQ_DEPTH = 2;

endpackage

### hw/rtl/itr_front.sv
module itr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [itr_pkg::OFFS_W-1:0] i_cfg_data,
    input  logic                       i_accept,
    input  logic                       i_func,
    input  logic [itr_pkg::LEN_W-1:0]  i_dgram_len,
    input  logic [itr_pkg::WORD_W-1:0] i_seq_word,
    input  logic [itr_pkg::WORD_W-1:0] i_magic_word,
    input  logic [itr_pkg::WORD_W-1:0] i_image_len,
    output logic                       o_job_push,
    output itr_pkg::t_job              o_job
);

    logic [itr_pkg::OFFS_W-1:0] r_part, r_resv;
    logic [itr_pkg::WORD_W-1:0] r_total, n_total;
    logic [itr_pkg::WORD_W-1:0] r_next, n_next;
    logic [itr_pkg::WORD_W-1:0] r_remain, n_remain;

    logic                       idle;
    logic                       start_ok;
    logic [itr_pkg::OFFS_W-1:0] limit;
    logic [itr_pkg::WORD_W-1:0] tlen;
    logic                       fits;
    logic [itr_pkg::CNT_W-1:0]  sz;
    logic                       run_ok;
    logic [itr_pkg::WORD_W-1:0] next_new;
    logic                       done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= itr_pkg::PARTITION_SIZE_RST;
            r_resv <= itr_pkg::RESERVED_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                itr_pkg::CFG_PARTITION_SIZE: r_part <= i_cfg_data;
                itr_pkg::CFG_RESERVED_BYTES: r_resv <= i_cfg_data;
                default:                     r_part <= r_part;
            endcase
        end
    end

    // start checks while idle
    assign idle     = (r_total == '0);
    assign start_ok = (i_func == itr_pkg::FUNC_DGRAM)
                   && (i_dgram_len == itr_pkg::LEN_W'(itr_pkg::PAGE_BYTES + itr_pkg::SEQ_BYTES))
                   && (i_seq_word == '0)
                   && (i_magic_word == itr_pkg::MAGIC_WOLF);
    assign limit    = (r_resv >= r_part) ? '0 : (r_part - r_resv);
    assign tlen     = i_image_len + itr_pkg::WORD_W'(itr_pkg::HEADER_BYTES);
    assign fits     = (tlen <= {{(itr_pkg::WORD_W-itr_pkg::OFFS_W){1'b0}}, limit});

    // page checks while running, remain tracks total minus next
    assign sz       = (r_remain < itr_pkg::WORD_W'(itr_pkg::PAGE_BYTES))
                    ? r_remain[itr_pkg::CNT_W-1:0] : itr_pkg::CNT_W'(itr_pkg::PAGE_BYTES);
    assign run_ok   = (i_func == itr_pkg::FUNC_DGRAM)
                   && ({1'b0, i_dgram_len} >= ({1'b0, sz} + 10'(itr_pkg::SEQ_BYTES)))
                   && (i_seq_word == r_next);
    assign next_new = r_next + {{(itr_pkg::WORD_W-itr_pkg::CNT_W){1'b0}}, sz};
    assign done     = (next_new >= r_total);

    // classify the item and pick the next state
    always_comb begin
        n_total    = r_total;
        n_next     = r_next;
        n_remain   = r_remain;
        o_job_push = 1'b0;
        o_job.kind = itr_pkg::JOB_REJECT;
        o_job.woff = r_next[itr_pkg::OFFS_W-1:0];
        o_job.wcnt = sz;
        o_job.ack  = r_next;
        o_job.moff = r_part - itr_pkg::OFFS_W'(itr_pkg::MARKER_BYTES);
        if (idle) begin
            o_job.kind = itr_pkg::JOB_START;
            o_job.woff = '0;
            o_job.wcnt = itr_pkg::CNT_W'(itr_pkg::PAGE_BYTES);
            o_job.ack  = itr_pkg::WORD_W'(itr_pkg::PAGE_BYTES);
            if (i_accept && start_ok && fits) begin
                o_job_push = 1'b1;
                n_total    = tlen;
                n_next     = itr_pkg::WORD_W'(itr_pkg::PAGE_BYTES);
                n_remain   = i_image_len;
            end
        end else begin
            o_job_push = i_accept;
            if (!run_ok) begin
                o_job.kind = itr_pkg::JOB_REJECT;
            end else if (done) begin
                o_job.kind = itr_pkg::JOB_DONE;
                o_job.ack  = r_total;
                if (i_accept) begin
                    n_total = '0;
                    n_next  = '0;
                end
            end else begin
                o_job.kind = itr_pkg::JOB_PAGE;
                o_job.ack  = next_new;
                if (i_accept) begin
                    n_next   = next_new;
                    n_remain = r_remain - {{(itr_pkg::WORD_W-itr_pkg::CNT_W){1'b0}}, sz};
                end
            end
        end
    end

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_next  <= '0;
        end else begin
            r_total <= n_total;
            r_next  <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
    end

    // a running transfer always pushes exactly one job per item
    a_run_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!idle && i_accept) |-> o_job_push)
        else $error("running item did not produce a job");

endmodule

### hw/rtl/itr_jobq.sv
module itr_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output itr_pkg::t_job o_job
);

    localparam int unsigned PTR_W = $clog2(itr_pkg::JOBQ_DEPTH);
    localparam int unsigned CNT_W = $clog2(itr_pkg::JOBQ_DEPTH + 1);

    itr_pkg::t_job    r_mem [itr_pkg::JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(itr_pkg::JOBQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(itr_pkg::JOBQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(itr_pkg::JOBQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(itr_pkg::JOBQ_DEPTH))
        else $error("job queue count out of range");

endmodule

### hw/rtl/itr_back.sv
module itr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  itr_pkg::t_job   i_job,
    output logic            o_job_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output itr_pkg::t_result o_res
);

    logic [1:0]       r_step, n_step;
    logic             r_ovalid;
    itr_pkg::t_result r_out;
    itr_pkg::t_result res;
    logic             res_last;
    logic             emit;

    // result for the current job step
    always_comb begin
        res.action       = itr_pkg::ACT_ACK;
        res.flash_offset = '0;
        res.byte_count   = '0;
        res.ack_value    = '0;
        res.last         = 1'b0;
        res_last         = 1'b1;
        unique case (i_job.kind)
            itr_pkg::JOB_START: begin
                priority case (r_step)
                    2'd0: begin
                        res.action = itr_pkg::ACT_ERASE;
                        res_last   = 1'b0;
                    end
                    2'd1: begin
                        res.action       = itr_pkg::ACT_WRITE;
                        res.flash_offset = i_job.woff;
                        res.byte_count   = i_job.wcnt;
                        res_last         = 1'b0;
                    end
                    default: begin
                        res.ack_value = i_job.ack;
                    end
                endcase
            end
            itr_pkg::JOB_PAGE: begin
                if (r_step == 2'd0) begin
                    res.action       = itr_pkg::ACT_WRITE;
                    res.flash_offset = i_job.woff;
                    res.byte_count   = i_job.wcnt;
                    res_last         = 1'b0;
                end else begin
                    res.ack_value = i_job.ack;
                end
            end
            itr_pkg::JOB_DONE: begin
                priority case (r_step)
                    2'd0: begin
                        res.action       = itr_pkg::ACT_WRITE;
                        res.flash_offset = i_job.woff;
                        res.byte_count   = i_job.wcnt;
                        res_last         = 1'b0;
                    end
                    2'd1: begin
                        res.ack_value = i_job.ack;
                        res_last      = 1'b0;
                    end
                    default: begin
                        res.action       = itr_pkg::ACT_MARKER;
                        res.flash_offset = i_job.moff;
                        res.byte_count   = itr_pkg::CNT_W'(itr_pkg::MARKER_BYTES);
                    end
                endcase
            end
            itr_pkg::JOB_REJECT: begin
                res.ack_value = i_job.ack;
            end
            default: begin
                res.ack_value = i_job.ack;
            end
        endcase
        res.last = res_last;
    end

    // one result leaves the job per cycle when the output stage has room
    assign emit      = i_job_valid && (!r_ovalid || i_pop);
    assign o_job_pop = emit && res_last;
    assign n_step    = emit ? (res_last ? 2'd0 : r_step + 2'd1) : r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_empty = !r_ovalid;
    assign o_res   = r_out;

    a_step_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 2'd0) |-> i_job_valid)
        else $error("job left the queue in the middle of its results");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 2'd3)
        else $error("job step out of range");

endmodule

### hw/rtl/image_transfer_receiver.sv
// channel   direction  handshake              payload
// input     in         push / full            i_func i_dgram_len i_seq_word i_magic_word i_image_len
// result    out        empty / pop            o_action o_flash_offset o_byte_count o_ack_value o_last
// config    in         i_cfg_we (no wait)     i_cfg_idx i_cfg_data
//
// an input item is classified in the cycle it is taken; a two-entry job queue sits behind it
// the back end sends one result per cycle while its result register has room: 3 for a start
// or a completion, 2 for a page, 1 for a rejection, none for an ignored idle item; new items
// queue up meanwhile; pop frees the result register, so results flow every cycle while jobs wait
// reset is synchronous, active low: idle, queues empty, registers at 262144 and 8192
// full rises whenever both job slots are taken, even with pop high while a job drains
module image_transfer_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [itr_pkg::OFFS_W-1:0] i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_func,
    input  logic [itr_pkg::LEN_W-1:0]  i_dgram_len,
    input  logic [itr_pkg::WORD_W-1:0] i_seq_word,
    input  logic [itr_pkg::WORD_W-1:0] i_magic_word,
    input  logic [itr_pkg::WORD_W-1:0] i_image_len,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 o_action,
    output logic [itr_pkg::OFFS_W-1:0] o_flash_offset,
    output logic [itr_pkg::CNT_W-1:0]  o_byte_count,
    output logic [itr_pkg::WORD_W-1:0] o_ack_value,
    output logic                       o_last
);

    logic             accept;
    logic             job_push, job_pop, job_valid;
    itr_pkg::t_job    job_in, job_head;
    itr_pkg::t_result res;

    assign accept = push && !full;

    // front: classify and keep transfer state
    itr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_dgram_len  (i_dgram_len),
        .i_seq_word   (i_seq_word),
        .i_magic_word (i_magic_word),
        .i_image_len  (i_image_len),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    // queue between front and back
    itr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job_head)
    );

    // back: expand jobs into results
    itr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_action       = res.action;
    assign o_flash_offset = res.flash_offset;
    assign o_byte_count   = res.byte_count;
    assign o_ack_value    = res.ack_value;
    assign o_last         = res.last;

endmodule
